FILE: design/task_dependency_scheduler_defines.svh
// Assertion macros for the task dependency scheduler
`ifndef TASK_DEPENDENCY_SCHEDULER_DEFINES_SVH
`define TASK_DEPENDENCY_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define TDS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define TDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define TDS_ASSERT_IMPL(label, ante, cons)
`define TDS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/tds_pkg.sv
// Shared types and codes for the task dependency scheduler
`timescale 1ns / 1ps
package tds_pkg;
  localparam int ID_W    = 5;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 3;
  localparam int DEG_W   = 9;
  localparam logic [DEG_W-1:0] DEGREE_MAX = 9'd511;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_EDGE     = 3'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
  localparam logic [OP_W-1:0] OP_ABORT    = 3'd4;

  localparam logic [KIND_W-1:0] EV_POOL   = 3'd0;
  localparam logic [KIND_W-1:0] EV_HOST   = 3'd1;
  localparam logic [KIND_W-1:0] EV_ABORT  = 3'd2;
  localparam logic [KIND_W-1:0] EV_DONE   = 3'd3;
  localparam logic [KIND_W-1:0] EV_EMPTY  = 3'd4;
  localparam logic [KIND_W-1:0] EV_REJECT = 3'd5;
  localparam logic [KIND_W-1:0] EV_ACK    = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] node_id;
    logic [ID_W-1:0] target_id;
    logic            has_host;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   node_id_out;
    logic              last;
  } out_item_t;

  // sequencer to result buffer
  typedef struct packed {
    logic              push;
    logic              flush;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } emit_req_t;
endpackage

FILE: design/tds_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: design/tds_emit.sv
// Result buffer: one held result plus the output register, sets last on flush
`timescale 1ns / 1ps
module tds_emit import tds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  emit_req_t req,
  output logic      rdy,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic              held_v_r, held_v_nxt;
  logic [KIND_W-1:0] held_kind_r, held_kind_nxt;
  logic [ID_W-1:0]   held_id_r, held_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              can_push, push_out;

  assign can_push = !out_valid_r || out_ready;
  assign rdy      = req.flush ? can_push : (!held_v_r || can_push);
  assign push_out = held_v_r && can_push && (req.push || req.flush);

  always_comb begin
    held_v_nxt    = held_v_r;
    held_kind_nxt = held_kind_r;
    held_id_nxt   = held_id_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (push_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.event_kind  = held_kind_r;
      out_data_nxt.node_id_out = held_id_r;
      out_data_nxt.last        = req.flush;
    end
    if (req.push && rdy) begin
      held_v_nxt    = 1'b1;
      held_kind_nxt = req.kind;
      held_id_nxt   = req.id;
    end else if (req.flush && can_push) begin
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    held_kind_r <= held_kind_nxt;
    held_id_r   <= held_id_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

FILE: design/tds_ctrl.sv
// Sequencer with node, pending and successor stores
`timescale 1ns / 1ps
module tds_ctrl import tds_pkg::*; #(
  parameter int MAX_NODES      = 32,
  parameter int MAX_SUCCESSORS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output emit_req_t em,
  input  logic      em_rdy
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int SW = $clog2(MAX_SUCCESSORS + 1);
  localparam int LD = MAX_NODES * MAX_SUCCESSORS;
  localparam int LW = $clog2(LD);
  localparam int XW = ID_W + CW;

  typedef struct packed {
    logic             host;
    logic [DEG_W-1:0] indeg;
    logic [SW-1:0]    succ;
  } node_t;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_EDGE_A  = 11'b00000000010,
    S_EDGE_B  = 11'b00000000100,
    S_EDGE_W2 = 11'b00000001000,
    S_DISP_WR = 11'b00000010000,
    S_DISP_END= 11'b00000100000,
    S_REL_CNT = 11'b00001000000,
    S_REL_RDP = 11'b00010000000,
    S_REL_UPD = 11'b00100000000,
    S_REL_END = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   node_count_r, node_count_nxt;
  logic [CW-1:0]   completed_r, completed_nxt;
  logic            running_r, running_nxt;
  in_item_t        req_r, req_nxt;
  logic [NW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   k_r, k_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [NW-1:0]   t_r, t_nxt;
  logic            any_r, any_nxt;
  node_t           ea_r, ea_nxt;

  logic            node_we, node_re;
  logic [NW-1:0]   node_waddr, node_raddr;
  node_t           node_wdata, node_rdata;
  logic            pend_we, pend_re;
  logic [NW-1:0]   pend_waddr, pend_raddr;
  logic [DEG_W-1:0] pend_wdata, pend_rdata;
  logic            sl_we, sl_re;
  logic [LW-1:0]   sl_waddr, sl_raddr;
  logic [NW-1:0]   sl_wdata, sl_rdata;

  logic [NW-1:0]   a_n, b_n;
  logic [LW-1:0]   sl_base;
  logic [CW-1:0]   comp;

  tds_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata));

  tds_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_pend (
    .clk, .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .re(pend_re), .raddr(pend_raddr), .rdata(pend_rdata));

  tds_ram #(.WIDTH(NW), .DEPTH(LD)) u_succ (
    .clk, .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .re(sl_re), .raddr(sl_raddr), .rdata(sl_rdata));

  assign in_ready = (state_r == S_IDLE);
  assign a_n      = NW'(req_r.node_id);
  assign b_n      = NW'(req_r.target_id);
  assign sl_base  = LW'(a_n) * LW'(MAX_SUCCESSORS);
  assign comp     = completed_r + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    completed_nxt  = completed_r;
    running_nxt    = running_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    t_nxt          = t_r;
    any_nxt        = any_r;
    ea_nxt         = ea_r;
    node_we = 1'b0; node_waddr = '0; node_wdata = '0; node_re = 1'b0; node_raddr = '0;
    pend_we = 1'b0; pend_waddr = '0; pend_wdata = '0; pend_re = 1'b0; pend_raddr = '0;
    sl_we   = 1'b0; sl_waddr   = '0; sl_wdata   = '0; sl_re   = 1'b0; sl_raddr   = '0;
    em = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          any_nxt   = 1'b0;
          k_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = S_FIN;
          em.push   = 1'b1;
          em.kind   = EV_REJECT;
          unique case (in_data.opcode)
            OP_INSERT: begin
              if (!running_r && node_count_r < CW'(MAX_NODES)) begin
                node_we        = 1'b1;
                node_waddr     = NW'(node_count_r);
                node_wdata     = '{host: in_data.has_host, indeg: '0, succ: '0};
                em.kind        = EV_ACK;
                em.id          = ID_W'(node_count_r);
                node_count_nxt = node_count_r + CW'(1);
              end
            end
            OP_EDGE: begin
              if (!running_r && XW'(in_data.node_id) < XW'(node_count_r) &&
                  XW'(in_data.target_id) < XW'(node_count_r)) begin
                em.push    = 1'b0;
                node_re    = 1'b1;
                node_raddr = NW'(in_data.node_id);
                state_nxt  = S_EDGE_A;
              end
            end
            OP_DISPATCH: begin
              if (!running_r) begin
                if (node_count_r == '0) begin
                  em.kind = EV_EMPTY;
                end else begin
                  em.push    = 1'b0;
                  node_re    = 1'b1;
                  node_raddr = '0;
                  state_nxt  = S_DISP_WR;
                end
              end
            end
            OP_COMPLETE, OP_ABORT: begin
              if (running_r && XW'(in_data.node_id) < XW'(node_count_r)) begin
                em.push    = 1'b0;
                node_re    = 1'b1;
                node_raddr = NW'(in_data.node_id);
                state_nxt  = S_REL_CNT;
              end
            end
            default: ;
          endcase
        end
      end

      S_EDGE_A: begin
        ea_nxt     = node_rdata;
        node_re    = 1'b1;
        node_raddr = b_n;
        state_nxt  = S_EDGE_B;
      end

      S_EDGE_B: begin
        em.push   = 1'b1;
        state_nxt = S_FIN;
        if (ea_r.succ >= SW'(MAX_SUCCESSORS) || node_rdata.indeg >= DEGREE_MAX) begin
          em.kind = EV_REJECT;
        end else begin
          sl_we      = 1'b1;
          sl_waddr   = sl_base + LW'(ea_r.succ);
          sl_wdata   = b_n;
          node_we    = 1'b1;
          node_waddr = a_n;
          node_wdata = ea_r;
          node_wdata.succ = ea_r.succ + SW'(1);
          if (a_n == b_n) begin
            // self edge: one entry carries both updates
            node_wdata.indeg = ea_r.indeg + DEG_W'(1);
            em.kind = EV_ACK;
            em.id   = req_r.node_id;
          end else begin
            em.push   = 1'b0;
            state_nxt = S_EDGE_W2;
          end
        end
      end

      S_EDGE_W2: begin
        node_we    = 1'b1;
        node_waddr = b_n;
        node_wdata = node_rdata;
        node_wdata.indeg = node_rdata.indeg + DEG_W'(1);
        em.push    = 1'b1;
        em.kind    = EV_ACK;
        em.id      = req_r.node_id;
        state_nxt  = S_FIN;
      end

      S_DISP_WR: begin
        pend_we    = 1'b1;
        pend_waddr = idx_r;
        pend_wdata = node_rdata.indeg;
        if (node_rdata.indeg == '0) begin
          em.push = 1'b1;
          em.kind = node_rdata.host ? EV_HOST : EV_POOL;
          em.id   = ID_W'(idx_r);
        end
        if (!em.push || em_rdy) begin
          if (em.push) begin
            any_nxt = 1'b1;
          end
          if (CW'(idx_r) + CW'(1) == node_count_r) begin
            state_nxt = S_DISP_END;
          end else begin
            idx_nxt    = idx_r + NW'(1);
            node_re    = 1'b1;
            node_raddr = idx_r + NW'(1);
          end
        end
      end

      S_DISP_END: begin
        state_nxt = S_FIN;
        if (!any_r) begin
          em.push = 1'b1;
          em.kind = EV_EMPTY;
        end else begin
          running_nxt   = 1'b1;
          completed_nxt = '0;
        end
      end

      S_REL_CNT: begin
        cnt_nxt = (node_rdata.succ > SW'(MAX_SUCCESSORS)) ? SW'(MAX_SUCCESSORS)
                                                           : node_rdata.succ;
        if (node_rdata.succ == '0) begin
          state_nxt = S_REL_END;
        end else begin
          sl_re     = 1'b1;
          sl_raddr  = sl_base;
          state_nxt = S_REL_RDP;
        end
      end

      S_REL_RDP: begin
        t_nxt      = sl_rdata;
        pend_re    = 1'b1;
        pend_raddr = sl_rdata;
        node_re    = 1'b1;
        node_raddr = sl_rdata;
        state_nxt  = S_REL_UPD;
      end

      S_REL_UPD: begin
        if (pend_rdata != '0) begin
          pend_we    = 1'b1;
          pend_waddr = t_r;
          pend_wdata = pend_rdata - DEG_W'(1);
          if (pend_rdata == DEG_W'(1)) begin
            em.push = 1'b1;
            em.kind = (req_r.opcode == OP_ABORT) ? EV_ABORT :
                      (node_rdata.host ? EV_HOST : EV_POOL);
            em.id   = ID_W'(t_r);
          end
        end
        // a stalled cycle repeats the same write, which is harmless
        if (!em.push || em_rdy) begin
          if (em.push) begin
            any_nxt = 1'b1;
          end
          if (k_r + SW'(1) == cnt_r) begin
            state_nxt = S_REL_END;
          end else begin
            k_nxt     = k_r + SW'(1);
            sl_re     = 1'b1;
            sl_raddr  = sl_base + LW'(k_r + SW'(1));
            state_nxt = S_REL_RDP;
          end
        end
      end

      S_REL_END: begin
        if (comp >= node_count_r) begin
          em.push = 1'b1;
          em.kind = EV_DONE;
        end else if (!any_r) begin
          em.push = 1'b1;
          em.kind = EV_ACK;
          em.id   = req_r.node_id;
        end
        if (!em.push || em_rdy) begin
          state_nxt = S_FIN;
          if (comp >= node_count_r) begin
            completed_nxt = '0;
            running_nxt   = 1'b0;
          end else begin
            completed_nxt = comp;
          end
        end
      end

      S_FIN: begin
        em.flush = 1'b1;
        if (em_rdy) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= '0;
      completed_r  <= '0;
      running_r    <= 1'b0;
      any_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      completed_r  <= completed_nxt;
      running_r    <= running_nxt;
      any_r        <= any_nxt;
    end
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    t_r   <= t_nxt;
    ea_r  <= ea_nxt;
  end
endmodule

FILE: design/task_dependency_scheduler.sv
// Top level of the task dependency scheduler
// Dependency-counting scheduler for a task graph. One request is taken at a
// time; in_ready is high only while the sequencer is idle. Each request is
// walked by one sequencer over the single read and write port of each store:
// an edge reads and updates both end nodes, dispatch visits every node, and a
// completion or abort visits each successor of the finished node.
// Results pass through a one-entry hold stage and an output register, so
// output back-pressure adds cycles but the next request may be taken while
// the last result still waits. Stores come up undefined; no clearing pass.
`timescale 1ns / 1ps
`include "task_dependency_scheduler_defines.svh"
module task_dependency_scheduler import tds_pkg::*; #(
  parameter int MAX_NODES      = 32,
  parameter int MAX_SUCCESSORS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  emit_req_t em;
  logic      em_rdy;

  tds_ctrl #(.MAX_NODES(MAX_NODES), .MAX_SUCCESSORS(MAX_SUCCESSORS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .em, .em_rdy);

  tds_emit u_emit (
    .clk, .rst_n, .req(em), .rdy(em_rdy), .out_valid, .out_ready, .out_data);

  `TDS_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `TDS_ASSERT_IMPL(a_done_is_last, out_valid && out_data.event_kind == EV_DONE, out_data.last)
  `TDS_ASSERT_IMPL(a_empty_is_last, out_valid && out_data.event_kind == EV_EMPTY, out_data.last)
endmodule
